### hw/rtl/apm_pkg.sv
// Shared types and constants for the automaton pattern matcher.
// Used by apm_next_state and automaton_pattern_matcher_top; no dependencies.
`default_nettype none

package apm_pkg;

  // Pattern storage is two 64-bit registers, byte 0 in the lowest bits
  localparam int PAT_BYTES  = 16;
  localparam int PB_W       = $clog2(PAT_BYTES);
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

  // Register index, taken from paddr[4:3] (registers sit 8 bytes apart)
  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

### hw/rtl/apm_next_state.sv
// Transition function of the string-matching automaton: next matched length
// and full-match flag from the current length, the text byte and the pattern.
// Depends on apm_pkg.
`default_nettype none

module apm_next_state import apm_pkg::*; #(
  parameter int MAX_PATTERN = 16,
  localparam int QW = $clog2(MAX_PATTERN + 1)
) (
  input  pat_bytes_t    pattern,
  input  logic [QW-1:0] eff_len,    // 1..MAX_PATTERN
  input  logic [QW-1:0] cur_len,    // 0..MAX_PATTERN-1
  input  logic [7:0]    text_byte,
  output logic          hit,
  output logic [QW-1:0] next_len
);

  // border[q][l]: pattern[0..l-1] equals pattern[q-l..q-1] (l <= q).
  // Depends on the pattern alone.
  logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] border;

  always_comb begin
    logic [PB_W-1:0] src;
    src = '0;
    for (int qq = 0; qq < MAX_PATTERN; qq++) begin
      for (int l = 0; l < MAX_PATTERN; l++) begin
        border[qq][l] = (l <= qq);
        for (int i = 0; i < MAX_PATTERN; i++) begin
          src = PB_W'(qq - l + i);
          if (i < l && l <= qq) begin
            border[qq][l] = border[qq][l] & (pattern[src] == pattern[i]);
          end
        end
      end
    end
  end

  // Pick the row for the current matched length
  logic [MAX_PATTERN-1:0] row;

  always_comb begin
    row = '0;
    for (int qq = 0; qq < MAX_PATTERN; qq++) begin
      if (cur_len == QW'(qq)) begin
        row = border[qq];
      end
    end
  end

  // Candidate k: k <= cur_len+1, k <= eff_len, last byte matches, rest is a border.
  // Highest candidate wins.
  logic [QW:0]   lim;
  logic [QW-1:0] best;

  always_comb begin
    lim  = {1'b0, cur_len} + (QW+1)'(1);
    best = '0;
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      if ((QW+1)'(k) <= lim && QW'(k) <= eff_len &&
          pattern[k-1] == text_byte && row[k-1]) begin
        best = QW'(k);
      end
    end
  end

  // A full match restarts from zero, so occurrences never overlap
  assign hit      = (best == eff_len);
  assign next_len = hit ? '0 : best;

endmodule

`default_nettype wire

### hw/rtl/automaton_pattern_matcher_top.sv
// Top level of the automaton pattern matcher: stream ports, APB register
// file, item register, match state and output register.
// Depends on apm_pkg and apm_next_state.
`default_nettype none

// Searches a byte stream for a pattern of 1 to 16 bytes (APB registers at
// 0x00 low bytes, 0x08 high bytes, 0x10 length) and sends the text index
// where each non-overlapping occurrence begins. tuser marks the first byte of
// a new text, which clears the match state and restarts indexing at zero.
// One byte is taken every cycle while the output side does not stall: the
// full automaton transition is combinational logic between the item register
// and the state/output registers, so the sustained rate is one byte per clock.
// A match index is loaded into the output register when the byte completing
// it advances out of the item register. While a match waits on m_tready, a
// byte already held in the item register stalls the input. The byte index
// saturates at its maximum; match_start is the start index, low 32 bits.

module automaton_pattern_matcher_top import apm_pkg::*; #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // text input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] text_byte
  input  logic                  s_tuser,   // [0] text_start
  // match output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [31:0] match_start
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int QW = $clog2(MAX_PATTERN + 1);
  localparam int SW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  // ---------------- configuration registers ----------------
  logic [63:0] pattern_low_bytes;
  logic [63:0] pattern_high_bytes;
  logic [4:0]  pattern_length;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      pattern_length     <= 5'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAT_LO:  pattern_low_bytes  <= pwdata;
        REG_PAT_HI:  pattern_high_bytes <= pwdata;
        REG_PAT_LEN: pattern_length     <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_PAT_LO:  prdata = pattern_low_bytes;
      REG_PAT_HI:  prdata = pattern_high_bytes;
      REG_PAT_LEN: prdata = {59'd0, pattern_length};
      default:     prdata = '0;
    endcase
  end

  // effective length: zero acts as one, clamp at MAX_PATTERN
  logic [QW-1:0] eff_len;
  pat_bytes_t    pattern;

  assign pattern = {pattern_high_bytes, pattern_low_bytes};

  always_comb begin
    if (pattern_length == 5'd0) begin
      eff_len = QW'(1);
    end else if (pattern_length > 5'(MAX_PATTERN)) begin
      eff_len = QW'(MAX_PATTERN);
    end else begin
      eff_len = QW'(pattern_length);
    end
  end

  // ---------------- item register ----------------
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       out_free;
  logic       s1_adv;

  assign out_free = ~m_tvalid | m_tready;
  assign s1_adv   = s1_valid & out_free;
  assign s_tready = ~s1_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte  <= s_tdata;
      s1_start <= s_tuser;
    end
  end

  // ---------------- match state and transition ----------------
  logic [QW-1:0]            matched_length;
  logic [POSITION_BITS-1:0] byte_position;
  logic [QW-1:0]            cur_len;
  logic [POSITION_BITS-1:0] idx;
  logic [POSITION_BITS-1:0] byte_position_next;
  logic                     hit;
  logic [QW-1:0]            matched_length_next;

  // a new text clears state before its first byte
  assign cur_len = s1_start ? '0 : matched_length;
  assign idx     = s1_start ? '0 : byte_position;
  assign byte_position_next = (&idx) ? idx : idx + POSITION_BITS'(1);

  apm_next_state #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_next_state (
    .pattern   (pattern),
    .eff_len   (eff_len),
    .cur_len   (cur_len),
    .text_byte (s1_byte),
    .hit       (hit),
    .next_len  (matched_length_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      matched_length <= '0;
      byte_position  <= '0;
    end else if (s1_adv) begin
      matched_length <= matched_length_next;
      byte_position  <= byte_position_next;
    end
  end

  // start index of the occurrence, low 32 bits
  logic [SW-1:0] idx_w;
  logic [SW-1:0] start_w;

  assign idx_w   = SW'(idx);
  assign start_w = idx_w - SW'(eff_len) + SW'(1);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_adv & hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && hit) begin
      m_tdata <= start_w[31:0];
    end
  end

  // ---------------- assertions ----------------
  // matched length stays below the largest pattern
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    matched_length < QW'(MAX_PATTERN))
    else $error("matched_length out of range");

  // a completed match restarts the automaton
  a_hit_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && hit |=> matched_length == '0)
    else $error("match did not clear matched_length");

  // first byte of a text takes index zero
  a_start_index: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_start |=> byte_position == POSITION_BITS'(1))
    else $error("text start did not restart byte index");

  // input side never stalls while the output register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire

### test/automaton_pattern_matcher_top_tb.sv
// Self-checking testbench for automaton_pattern_matcher_top: text bytes go in
// over the slave stream, match start indexes are predicted and checked at the
// master stream. Depends on apm_pkg and the matcher RTL only.

module automaton_pattern_matcher_top_tb;
  import apm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 200;
  localparam int PIPE_SETTLE  = 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] text_byte
  logic                  s_tuser = 1'b0; // [0] text_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;        // [31:0] match_start
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  automaton_pattern_matcher_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Matcher state mirrored by the predictor
  logic [63:0] pat_lo_cfg  = '0;
  logic [63:0] pat_hi_cfg  = '0;
  logic [4:0]  pat_len_cfg = 5'd1;
  int unsigned match_len   = 0;
  logic [31:0] text_pos    = '0;

  logic [31:0] expected_starts[$];
  logic [31:0] start_due;
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          ready_mode = 0;
  int          ready_hold = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("automaton_pattern_matcher_top_tb: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: a randomly chosen mode, held for a random span
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(20, 150);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (ready_hold[1:0] == 2'd0);
    endcase
  end

  // Compare every output transfer with the oldest predicted start index
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_starts.size() == 0) begin
        $display("%0t: match_start expected none, got %0d", $time, m_tdata);
        mismatches++;
      end else begin
        start_due = expected_starts.pop_front();
        if (m_tdata !== start_due) begin
          $display("%0t: match_start expected %0d, got %0d", $time, start_due, m_tdata);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [7:0] pattern_byte(int unsigned i);
    logic [63:0] word;
    int unsigned j;
    j = i & 15;
    word = (j < 8) ? pat_lo_cfg : pat_hi_cfg;
    return word[(j & 7) * 8 +: 8];
  endfunction

  function automatic int unsigned effective_len();
    if (pat_len_cfg == 5'd0) return 1;
    if (pat_len_cfg > 5'd16) return 16;
    return 32'(pat_len_cfg);
  endfunction

  // Longest pattern prefix that ends the matched prefix followed by x
  function automatic int unsigned longest_border(int unsigned q, logic [7:0] x,
                                                 int unsigned m);
    int unsigned k;
    int unsigned i;
    bit ok;
    k = (q + 1 < m) ? q + 1 : m;
    while (k > 0) begin
      ok = (pattern_byte(k - 1) == x);
      for (i = 0; ok && i + 1 < k; i++) begin
        if (pattern_byte(i) != pattern_byte(q + 1 - k + i)) ok = 1'b0;
      end
      if (ok) return k;
      k--;
    end
    return 0;
  endfunction

  // Advance the mirrored automaton by one accepted byte
  task automatic predict_byte(logic [7:0] x, logic first);
    int unsigned m;
    int unsigned q;
    logic [31:0] idx;
    m = effective_len();
    if (first) begin
      match_len = 0;
      text_pos = '0;
    end
    idx = text_pos;
    if (idx != 32'hFFFF_FFFF) text_pos = idx + 32'd1;
    q = (match_len > 16) ? 16 : match_len;
    q = longest_border(q, x, m);
    if (q >= m) begin
      match_len = 0;
      expected_starts = {expected_starts, idx - 32'(m) + 32'd1};
    end else begin
      match_len = q;
    end
  endtask

  // One text byte, sent in bursts with random gaps
  task automatic send_byte(logic [7:0] x, logic first);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    s_tuser <= first;
    do @(posedge clk); while (!s_tready);
    predict_byte(x, first);
    burst_left--;
  endtask

  // Drain outstanding matches and let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_starts.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // APB write: setup then access cycle
  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PAT_LO:  pat_lo_cfg = value;
      REG_PAT_HI:  pat_hi_cfg = value;
      REG_PAT_LEN: pat_len_cfg = value[4:0];
      default: ;
    endcase
  endtask

  // Reset pattern is a single zero byte
  task automatic test_reset_pattern();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  // A length of zero behaves as one
  task automatic test_zero_length();
    wait_idle();
    write_reg(REG_PAT_LO, 64'h0000_0000_0000_00FF);
    write_reg(REG_PAT_LEN, 64'd0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);
  endtask

  // A length above the maximum behaves as sixteen
  task automatic test_oversize_length();
    int i;
    wait_idle();
    write_reg(REG_PAT_LO, 64'h8877_6655_4433_2211);
    write_reg(REG_PAT_HI, 64'h00FF_EEDD_CCBB_AA99);
    write_reg(REG_PAT_LEN, 64'd31);
    for (i = 0; i < 16; i++) send_byte(pattern_byte(i), i == 0);
  endtask

  // Partial-match fallback, then a shorter length with a prefix still held
  task automatic test_fallback_and_shrink();
    wait_idle();
    write_reg(REG_PAT_LO, 64'h0000_0000_0062_6161);
    write_reg(REG_PAT_LEN, 64'd3);
    send_byte(8'h61, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    wait_idle();
    write_reg(REG_PAT_LEN, 64'd1);
    send_byte(8'h61, 1'b0);
  endtask

  // Random patterns over small alphabets; text is mostly pattern copies
  task automatic test_random_text();
    int phase;
    int sent;
    int r;
    int i;
    int m;
    int copy_len;
    int bad_at;
    int alpha_n;
    logic [7:0] alphabet[3];
    logic [7:0] x;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0] len;
    logic restart;
    bit full_random;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      alpha_n = $urandom_range(1, 3);
      for (i = 0; i < 3; i++) alphabet[i] = 8'($urandom_range(0, 255));
      full_random = ($urandom_range(0, 4) == 0);
      for (i = 0; i < 8; i++) begin
        lo[i*8 +: 8] = full_random ? 8'($urandom) : alphabet[$urandom_range(0, alpha_n - 1)];
        hi[i*8 +: 8] = full_random ? 8'($urandom) : alphabet[$urandom_range(0, alpha_n - 1)];
      end
      if (phase == 0) len = 5'd16;
      else if (phase == 1) len = 5'd1;
      else begin
        case ($urandom_range(0, 5))
          0: len = 5'd1;
          1: len = 5'd16;
          2: len = 5'd0;
          3: len = 5'($urandom_range(17, 31));
          default: len = 5'($urandom_range(2, 15));
        endcase
      end
      write_reg(REG_PAT_LO, lo);
      write_reg(REG_PAT_HI, hi);
      write_reg(REG_PAT_LEN, {$urandom, 27'($urandom), len});
      m = effective_len();
      restart = (phase % 2 == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          copy_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, m) : m;
          bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, copy_len - 1) : -1;
          for (i = 0; i < copy_len; i++) begin
            x = (i == bad_at) ? 8'($urandom) : pattern_byte(i);
            send_byte(x, restart || ($urandom_range(0, 199) == 0));
            restart = 1'b0;
            sent++;
          end
        end else begin
          x = (r < 90) ? alphabet[$urandom_range(0, alpha_n - 1)] : 8'($urandom);
          send_byte(x, restart || ($urandom_range(0, 49) == 0));
          restart = 1'b0;
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_pattern();
    test_zero_length();
    test_oversize_length();
    test_fallback_and_shrink();
    test_random_text();
    wait_idle();
    repeat (10) @(posedge clk);
    while (expected_starts.size() != 0) begin
      $display("%0t: match_start expected %0d, got none", $time, expected_starts.pop_front());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("automaton_pattern_matcher_top_tb: PASS");
    end else begin
      $display("automaton_pattern_matcher_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/apm_pkg.sv
hw/rtl/apm_next_state.sv
hw/rtl/automaton_pattern_matcher_top.sv
test/automaton_pattern_matcher_top_tb.sv
